### rtl/tiered_rate_group_scheduler_assert.svh
// assertion macros for the tiered rate group scheduler
`ifndef TIERED_RATE_GROUP_SCHEDULER_ASSERT_SVH
`define TIERED_RATE_GROUP_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TRGS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trgs check failed");

// next-cycle implication, checked outside reset
`define TRGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trgs check failed");

`endif

### rtl/trgs_pkg.sv
// shared types, codes and defaults of the tiered rate group scheduler
package trgs_pkg;

  localparam int NUM_TIERS_DEF      = 4;
  localparam int SLOTS_PER_TIER_DEF = 16;
  localparam int ID_BITS_DEF        = 8;

  // cap on run beats of one tick
  localparam int MAX_RUN   = 30;
  localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

  // request kinds
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // response kinds
  localparam logic [2:0] RESP_RUN     = 3'd0;
  localparam logic [2:0] RESP_NONE    = 3'd1;
  localparam logic [2:0] RESP_ADDED   = 3'd2;
  localparam logic [2:0] RESP_REMOVED = 3'd3;
  localparam logic [2:0] RESP_FULL    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;    // capture request, rewind scan
    logic scan_en;  // walk the slot table
    logic finish;   // emit final beat, commit table or counter
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;  // last slot evaluated this cycle
    logic out_free;   // output register can take a beat
  } dp_stat_t;

endpackage

### rtl/trgs_ctrl.sv
// controller state machine of the tiered rate group scheduler
module trgs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [1:0]          req_type,
  output logic                s_tready,
  input  trgs_pkg::dp_stat_t  stat,
  output trgs_pkg::ctrl_cmd_t cmd
);

  trgs_pkg::state_t state, state_next;
  logic known;

  assign known = (req_type == trgs_pkg::REQ_TICK) || (req_type == trgs_pkg::REQ_ADD) ||
                 (req_type == trgs_pkg::REQ_REMOVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trgs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      trgs_pkg::ST_IDLE: begin
        if (s_tvalid && known) state_next = trgs_pkg::ST_SCAN;
      end
      trgs_pkg::ST_SCAN: begin
        if (stat.scan_done) state_next = trgs_pkg::ST_FINISH;
      end
      trgs_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = trgs_pkg::ST_IDLE;
      end
      default: state_next = trgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      trgs_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid && known;
      end
      trgs_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      trgs_pkg::ST_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/trgs_dp.sv
// datapath of the tiered rate group scheduler: slot table, scan pipeline, output register
module trgs_dp #(
  parameter int NUM_TIERS      = trgs_pkg::NUM_TIERS_DEF,
  parameter int SLOTS_PER_TIER = trgs_pkg::SLOTS_PER_TIER_DEF,
  parameter int ID_BITS        = trgs_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  trgs_pkg::ctrl_cmd_t cmd,
  output trgs_pkg::dp_stat_t  stat,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_task_id,
  input  logic [1:0]          in_tier,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_id,
  output logic [1:0]          out_tier,
  output logic [3:0]          out_slot,
  output logic [3:0]          out_period,
  output logic [31:0]         out_cyc,
  output logic                out_last
);

  localparam int DEPTH  = NUM_TIERS * SLOTS_PER_TIER;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIER_W = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
  localparam int SLOT_W = (SLOTS_PER_TIER > 1) ? $clog2(SLOTS_PER_TIER) : 1;
  localparam int CNT_W  = trgs_pkg::RUN_CNT_W;

  function automatic logic [3:0] period_of(input logic [2:0] t);
    logic [7:0] p;
    p = 8'd1 << t;
    return p[3:0];
  endfunction

  // request
  logic [1:0]         req_kind;
  logic [ID_BITS-1:0] req_id;
  logic [1:0]         req_tier;
  logic [15:0]        id_wide;

  logic [31:0]        cycle_counter;

  // slot table: valid flags in flops, ids in memory
  logic [DEPTH-1:0]   valid;
  logic [ID_BITS-1:0] id_mem [DEPTH];
  logic [ID_BITS-1:0] rd_id;

  // issue stage
  logic [ADDR_W-1:0]  iss_addr;
  logic [TIER_W-1:0]  iss_tier;
  logic [SLOT_W-1:0]  iss_slot;
  logic               iss_done;
  logic               iss_last;

  // evaluate stage
  logic [ADDR_W-1:0]  ev_addr;
  logic [TIER_W-1:0]  ev_tier;
  logic [SLOT_W-1:0]  ev_slot;
  logic               ev_vld;
  logic               ev_last;

  // run beats held back one step so the final one can carry last
  logic               pend_vld;
  logic [ID_BITS-1:0] pend_id;
  logic [TIER_W-1:0]  pend_tier;
  logic [SLOT_W-1:0]  pend_slot;
  logic [CNT_W-1:0]   hit_cnt;

  // placement slot for add, first cleared slot for remove
  logic               found;
  logic [ADDR_W-1:0]  f_addr;
  logic [TIER_W-1:0]  f_tier;
  logic [SLOT_W-1:0]  f_slot;

  logic               ev_bit;
  logic               id_match;
  logic [7:0]         tmask;
  logic               due;
  logic               run_hit;
  logic               out_free;
  logic               stall;
  logic               advance;
  logic               rd_en;
  logic               mem_we;
  logic               clr_en;
  logic               place_cand;
  logic               rem_first;

  assign id_wide    = 16'(in_task_id);
  assign iss_last   = (iss_addr == ADDR_W'(DEPTH - 1));
  assign ev_bit     = valid[ev_addr];
  assign id_match   = ev_bit && (rd_id == req_id);
  assign tmask      = (8'd1 << ev_tier) - 8'd1;
  assign due        = (((8'(ev_slot)) ^ cycle_counter[7:0]) & tmask) == 8'd0;
  assign run_hit    = ev_vld && (req_kind == trgs_pkg::REQ_TICK) && ev_bit && due &&
                      (hit_cnt < CNT_W'(trgs_pkg::MAX_RUN));
  assign out_free   = !out_valid || out_ready;
  assign stall      = run_hit && pend_vld && !out_free;
  assign advance    = cmd.scan_en && !stall;
  assign rd_en      = advance && !iss_done;
  assign mem_we     = cmd.finish && (req_kind == trgs_pkg::REQ_ADD) && found;
  assign clr_en     = advance && ev_vld && (req_kind != trgs_pkg::REQ_TICK) && id_match;
  assign place_cand = ev_vld && (req_kind == trgs_pkg::REQ_ADD) && !found &&
                      (8'(ev_tier) == 8'(req_tier)) && (!ev_bit || id_match);
  assign rem_first  = ev_vld && (req_kind == trgs_pkg::REQ_REMOVE) && !found && id_match;

  assign stat.scan_done = cmd.scan_en && ev_vld && ev_last && !stall;
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[f_addr] <= req_id;
    end
    if (rd_en) begin
      rd_id <= id_mem[iss_addr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_kind <= in_req_type;
      req_id   <= id_wide[ID_BITS-1:0];
      req_tier <= in_tier;
    end
  end

  // valid flags, counter and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      cycle_counter <= '0;
      iss_done      <= 1'b1;
      ev_vld        <= 1'b0;
      pend_vld      <= 1'b0;
      found         <= 1'b0;
      hit_cnt       <= '0;
    end else begin
      if (clr_en) valid[ev_addr] <= 1'b0;
      if (mem_we) valid[f_addr] <= 1'b1;
      if (cmd.finish && (req_kind == trgs_pkg::REQ_TICK)) begin
        cycle_counter <= cycle_counter + 32'd1;
      end
      if (cmd.start) begin
        iss_done <= 1'b0;
        ev_vld   <= 1'b0;
        pend_vld <= 1'b0;
        found    <= 1'b0;
        hit_cnt  <= '0;
      end else if (advance) begin
        ev_vld <= !iss_done;
        if (!iss_done) iss_done <= iss_last;
        if (run_hit) begin
          pend_vld <= 1'b1;
          hit_cnt  <= hit_cnt + CNT_W'(1);
        end
        if (place_cand || rem_first) found <= 1'b1;
      end
    end
  end

  // scan addresses and captured slot positions
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      iss_addr <= '0;
      iss_tier <= '0;
      iss_slot <= '0;
    end else if (advance) begin
      if (!iss_done) begin
        ev_addr  <= iss_addr;
        ev_tier  <= iss_tier;
        ev_slot  <= iss_slot;
        ev_last  <= iss_last;
        iss_addr <= iss_addr + ADDR_W'(1);
        if (iss_slot == SLOT_W'(SLOTS_PER_TIER - 1)) begin
          iss_slot <= '0;
          iss_tier <= iss_tier + TIER_W'(1);
        end else begin
          iss_slot <= iss_slot + SLOT_W'(1);
        end
      end
      if (run_hit) begin
        pend_id   <= rd_id;
        pend_tier <= ev_tier;
        pend_slot <= ev_slot;
      end
      if (place_cand || rem_first) begin
        f_addr <= ev_addr;
        f_tier <= ev_tier;
        f_slot <= ev_slot;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((advance && run_hit && pend_vld) || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && run_hit && pend_vld) begin
      out_kind   <= trgs_pkg::RESP_RUN;
      out_id     <= 8'(pend_id);
      out_tier   <= 2'(pend_tier);
      out_slot   <= 4'(pend_slot);
      out_period <= period_of(3'(pend_tier));
      out_cyc    <= cycle_counter;
      out_last   <= 1'b0;
    end else if (cmd.finish) begin
      out_last <= 1'b1;
      unique case (req_kind)
        trgs_pkg::REQ_TICK: begin
          out_cyc <= cycle_counter;
          if (pend_vld) begin
            out_kind   <= trgs_pkg::RESP_RUN;
            out_id     <= 8'(pend_id);
            out_tier   <= 2'(pend_tier);
            out_slot   <= 4'(pend_slot);
            out_period <= period_of(3'(pend_tier));
          end else begin
            out_kind   <= trgs_pkg::RESP_NONE;
            out_id     <= '0;
            out_tier   <= '0;
            out_slot   <= '0;
            out_period <= '0;
          end
        end
        trgs_pkg::REQ_ADD: begin
          out_cyc  <= '0;
          out_id   <= 8'(req_id);
          out_tier <= req_tier;
          if (found) begin
            out_kind   <= trgs_pkg::RESP_ADDED;
            out_slot   <= 4'(f_slot);
            out_period <= period_of(3'(req_tier));
          end else begin
            out_kind   <= trgs_pkg::RESP_FULL;
            out_slot   <= '0;
            out_period <= '0;
          end
        end
        default: begin
          // remove
          out_cyc  <= '0;
          out_id   <= 8'(req_id);
          out_kind <= trgs_pkg::RESP_REMOVED;
          if (found) begin
            out_tier   <= 2'(f_tier);
            out_slot   <= 4'(f_slot);
            out_period <= period_of(3'(f_tier));
          end else begin
            out_tier   <= '0;
            out_slot   <= '0;
            out_period <= '0;
          end
        end
      endcase
    end
  end

endmodule

### rtl/tiered_rate_group_scheduler.sv
// top level of the tiered rate group scheduler
// A cyclic executive with power-of-two rate groups. The slot table holds
// NUM_TIERS tiers of SLOTS_PER_TIER slots; a task placed in tier t runs on
// every 2^t-th tick. A tick beat yields one run beat per due slot, in tier
// then slot order (at most 30), or a single none-due beat, then advances the
// 32-bit cycle counter; an add clears the id everywhere and takes the lowest
// free slot of its tier (or answers tier full); a remove clears the id and
// reports the first slot it held. The last beat of each request has tlast
// set. Requests are handled one at a time: the table ids sit in a
// single-port memory walked one slot per cycle, except while a run beat
// waits on a held-off result side; the final beat waits for it too.
// A request with an unknown kind is taken and dropped without a beat.
// After reset the table is empty and the cycle counter is zero; no
// clearing pass is needed.
module tiered_rate_group_scheduler #(
  parameter int NUM_TIERS      = trgs_pkg::NUM_TIERS_DEF,
  parameter int SLOTS_PER_TIER = trgs_pkg::SLOTS_PER_TIER_DEF,
  parameter int ID_BITS        = trgs_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // task_id [7:0], tier [9:8], zero fill
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // task_id_res [7:0], tier_res [9:8], slot [13:10],
                                 // period_ticks [17:14], cycle_number [49:18], zero fill
  output logic [2:0]  m_tuser,   // resp_kind [2:0]
  output logic        m_tlast    // last beat of the request
);

  trgs_pkg::ctrl_cmd_t cmd;
  trgs_pkg::dp_stat_t  stat;

  logic [7:0]  res_id;
  logic [1:0]  res_tier;
  logic [3:0]  res_slot;
  logic [3:0]  res_period;
  logic [31:0] res_cyc;

  trgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trgs_dp #(
    .NUM_TIERS      (NUM_TIERS),
    .SLOTS_PER_TIER (SLOTS_PER_TIER),
    .ID_BITS        (ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (s_tuser),
    .in_task_id  (s_tdata[7:0]),
    .in_tier     (s_tdata[9:8]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_id      (res_id),
    .out_tier    (res_tier),
    .out_slot    (res_slot),
    .out_period  (res_period),
    .out_cyc     (res_cyc),
    .out_last    (m_tlast)
  );

  // pack result fields, lowest field first
  assign m_tdata = {6'd0, res_cyc, res_period, res_slot, res_tier, res_id};

  `include "tiered_rate_group_scheduler_assert.svh"

  // a known request always enters the scan
  `TRGS_ASSERT_NEXT(a_start_scans, cmd.start, cmd.scan_en)
  // the final beat of a request is loaded with tlast set
  `TRGS_ASSERT_NEXT(a_finish_last, cmd.finish, m_tvalid && m_tlast)
  // no new request is taken while the table is being walked
  `TRGS_ASSERT_NOW(a_no_accept_in_scan, cmd.scan_en, !s_tready)

endmodule

### bench/testbench.sv
// self-checking bench for the tiered rate group scheduler
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REQ_BOGUS = 2'd3;  // unknown kind, dropped by the block
  localparam int QUIET_LIMIT = 4000;         // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 400;          // long result-side hold-off
  localparam int TAIL_CYCLES = 100;          // settle time after the last beat

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [1:0]  tier;
    logic [3:0]  slot;
    logic [3:0]  period;
    logic [31:0] cycle;
    logic        last;
  } sched_beat_t;

  // mirror of the slot table and cycle counter, plus the queue of beats it predicts
  class cyclic_exec_mirror;
    bit          used [trgs_pkg::NUM_TIERS_DEF][trgs_pkg::SLOTS_PER_TIER_DEF];
    bit [7:0]    held [trgs_pkg::NUM_TIERS_DEF][trgs_pkg::SLOTS_PER_TIER_DEF];
    bit [31:0]   ticks;
    sched_beat_t beat_q[$];
    int          errors;
    int          requests;
    int          beats;
    int          kind_seen [8];

    function sched_beat_t make_beat(logic [2:0] kind, logic [7:0] id, int tier,
                                    int slot, int period, logic [31:0] cycle);
      sched_beat_t b;
      b.kind   = kind;
      b.id     = id;
      b.tier   = 2'(tier);
      b.slot   = 4'(slot);
      b.period = 4'(period);
      b.cycle  = cycle;
      b.last   = 1'b0;
      return b;
    endfunction

    // drop the id from every slot, remembering the first one it held
    function bit purge_task(bit [7:0] id, output int ft, output int fs);
      bit found;
      found = 0;
      ft = 0;
      fs = 0;
      for (int t = 0; t < trgs_pkg::NUM_TIERS_DEF; t++)
        for (int s = 0; s < trgs_pkg::SLOTS_PER_TIER_DEF; s++)
          if (used[t][s] && held[t][s] == id) begin
            used[t][s] = 0;
            held[t][s] = 0;
            if (!found) begin
              found = 1;
              ft = t;
              fs = s;
            end
          end
      return found;
    endfunction

    function void take_request(bit [1:0] req, bit [7:0] id, bit [1:0] tr);
      sched_beat_t fresh[$];
      bit [31:0]   mask;
      bit          placed;
      int          ft, fs;
      requests++;
      placed = 0;
      case (req)
        trgs_pkg::REQ_TICK: begin
          for (int t = 0; t < trgs_pkg::NUM_TIERS_DEF; t++) begin
            mask = (32'd1 << t) - 32'd1;
            for (int s = 0; s < trgs_pkg::SLOTS_PER_TIER_DEF; s++)
              if (used[t][s] && ((s & mask) == (ticks & mask)) &&
                  fresh.size() < trgs_pkg::MAX_RUN)
                fresh.insert(fresh.size(),
                             make_beat(trgs_pkg::RESP_RUN, held[t][s], t, s, 1 << t, ticks));
          end
          if (fresh.size() == 0)
            fresh.insert(fresh.size(), make_beat(trgs_pkg::RESP_NONE, 8'd0, 0, 0, 0, ticks));
          ticks++;
        end
        trgs_pkg::REQ_ADD: begin
          void'(purge_task(id, ft, fs));
          if (tr < trgs_pkg::NUM_TIERS_DEF)
            for (int s = 0; s < trgs_pkg::SLOTS_PER_TIER_DEF; s++)
              if (!placed && !used[tr][s]) begin
                used[tr][s] = 1;
                held[tr][s] = id;
                fresh.insert(fresh.size(),
                             make_beat(trgs_pkg::RESP_ADDED, id, tr, s, 1 << tr, 32'd0));
                placed = 1;
              end
          if (!placed)
            fresh.insert(fresh.size(), make_beat(trgs_pkg::RESP_FULL, id, tr, 0, 0, 32'd0));
        end
        trgs_pkg::REQ_REMOVE: begin
          if (purge_task(id, ft, fs))
            fresh.insert(fresh.size(),
                         make_beat(trgs_pkg::RESP_REMOVED, id, ft, fs, 1 << ft, 32'd0));
          else
            fresh.insert(fresh.size(), make_beat(trgs_pkg::RESP_REMOVED, id, 0, 0, 0, 32'd0));
        end
        default: ;  // unknown kinds leave no trace
      endcase
      if (fresh.size() > 0) begin
        fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) beat_q.insert(beat_q.size(), fresh[i]);
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch %0d: %s", errors, what);
    endtask

    task match_beat(sched_beat_t got);
      sched_beat_t want;
      string       bad;
      if (beat_q.size() == 0) begin
        report($sformatf("beat with nothing pending: kind %0d id %0d", got.kind, got.id));
        return;
      end
      want = beat_q.pop_front();
      beats++;
      kind_seen[want.kind]++;
      bad = "";
      if (got.kind   !== want.kind)   bad = {bad, " kind"};
      if (got.id     !== want.id)     bad = {bad, " id"};
      if (got.tier   !== want.tier)   bad = {bad, " tier"};
      if (got.slot   !== want.slot)   bad = {bad, " slot"};
      if (got.period !== want.period) bad = {bad, " period"};
      if (got.cycle  !== want.cycle)  bad = {bad, " cycle"};
      if (got.last   !== want.last)   bad = {bad, " last"};
      if (bad != "")
        report($sformatf("beat %0d wrong%s: got %h want %h", beats, bad, got, want));
    endtask

    function int pending();
      return beat_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 0;
  int hold_left = 0;
  int quiet = 0;
  cyclic_exec_mirror mirror = new;

  tiered_rate_group_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin : watch
    sched_beat_t got;
    bit          moved;
    if (rst) begin
      quiet = 0;
    end else begin
      moved = 0;
      if (s_tvalid && s_tready) begin
        mirror.take_request(s_tuser, s_tdata[7:0], s_tdata[9:8]);
        moved = 1;
      end
      if (m_tvalid && m_tready) begin
        got.kind   = m_tuser;
        got.id     = m_tdata[7:0];
        got.tier   = m_tdata[9:8];
        got.slot   = m_tdata[13:10];
        got.period = m_tdata[17:14];
        got.cycle  = m_tdata[49:18];
        got.last   = m_tlast;
        mirror.match_beat(got);
        moved = 1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d beats pending",
                 quiet, mirror.pending());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] req, logic [7:0] id, logic [1:0] tr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {6'd0, tr, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every predicted beat
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
  endtask

  // mostly ids from a small pool so adds collide with earlier placements
  task automatic send_random(int count);
    int         sent;
    int         pick;
    logic [1:0] req;
    logic [7:0] id;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      id = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'(8'h20 + $urandom_range(47));
      if (pick < 38)      req = trgs_pkg::REQ_TICK;
      else if (pick < 72) req = trgs_pkg::REQ_ADD;
      else if (pick < 95) req = trgs_pkg::REQ_REMOVE;
      else                req = REQ_BOGUS;
      send_item(req, id, 2'($urandom_range(3)));
      if (req != REQ_BOGUS) sent++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty tick, absent remove, moves between tiers, unknown kind, full tier
    send_item(trgs_pkg::REQ_TICK, 8'h00, 2'd0);
    send_item(trgs_pkg::REQ_REMOVE, 8'h55, 2'd0);
    send_item(trgs_pkg::REQ_ADD, 8'h00, 2'd0);
    send_item(trgs_pkg::REQ_ADD, 8'hFF, 2'd3);
    send_item(trgs_pkg::REQ_ADD, 8'hFF, 2'd1);
    send_item(REQ_BOGUS, 8'hAA, 2'd2);
    send_item(trgs_pkg::REQ_REMOVE, 8'h00, 2'd0);
    for (int i = 0; i < trgs_pkg::SLOTS_PER_TIER_DEF; i++)
      send_item(trgs_pkg::REQ_ADD, 8'(8'h80 + i), 2'd2);
    // every slot of tier 2 is taken, so this one is turned away
    send_item(trgs_pkg::REQ_ADD, 8'hC3, 2'd2);
    send_item(trgs_pkg::REQ_TICK, 8'hFF, 2'd3);
    drain();

    // long hold-off on results while ticks keep coming, so the input backs up
    @(posedge clk);
    hold_go = 1;
    @(negedge clk);
    for (int i = 0; i < 6; i++) send_item(trgs_pkg::REQ_TICK, 8'h00, 2'd0);
    drain();

    set_idling(0, 0);
    send_random(32);
    drain();
    set_idling(77, 0);
    send_random(32);
    drain();
    set_idling(0, 77);
    send_random(32);
    drain();
    set_idling(30, 30);
    send_random(32);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d beats: %0d runs, %0d none due, %0d tier full",
             mirror.requests, mirror.beats, mirror.kind_seen[trgs_pkg::RESP_RUN],
             mirror.kind_seen[trgs_pkg::RESP_NONE], mirror.kind_seen[trgs_pkg::RESP_FULL]);
    $display("idle mixes none, sender, receiver and both, plus a %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (mirror.errors == 0 && mirror.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
